/* rtl/skl_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// skl_pkg: shared definitions for the sorted key list table
// Field widths, command and status codes, and the per-cell command bundle.
// ----------------------------------------------------------------------------
package skl_pkg;

   localparam int SKL_CAPACITY   = 16;

   localparam int SKL_CMD_W      = 2;
   localparam int SKL_KEY_W      = 32;
   localparam int SKL_HND_W      = 16;
   localparam int SKL_SLOT_W     = 4;
   localparam int SKL_STAT_W     = 2;
   localparam int SKL_OUT_IDX_W  = 4;
   localparam int SKL_OUT_CNT_W  = 5;

   localparam logic [SKL_CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [SKL_CMD_W-1:0] CMD_LOOKUP = 2'd1;
   localparam logic [SKL_CMD_W-1:0] CMD_READ   = 2'd2;
   localparam logic [SKL_CMD_W-1:0] CMD_REMOVE = 2'd3;

   localparam logic [SKL_STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [SKL_STAT_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [SKL_STAT_W-1:0] ST_FULL      = 2'd2;
   localparam logic [SKL_STAT_W-1:0] ST_RANGE     = 2'd3;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic                 insert_en;
      logic                 remove_en;
      logic [SKL_KEY_W-1:0] key;
      logic [SKL_HND_W-1:0] handle;
   } skl_cell_cmd_type;

endpackage
`default_nettype wire

/* rtl/skl_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// skl_cell: one slot of the sorted chain
// Holds one key/handle pair, compares it against the command key and
// shifts toward the tail on insert or toward the head on remove.
// ----------------------------------------------------------------------------
module skl_cell
   import skl_pkg::*;
(
   input  wire logic                 clock,
   input  wire skl_cell_cmd_type     cmd,
   input  wire logic                 occupied,    // slot lies below the count
   input  wire logic                 prev_le,     // left neighbor stays put on insert
   input  wire logic                 from_index,  // slot at or after the removed one
   input  wire logic [SKL_KEY_W-1:0] left_key,
   input  wire logic [SKL_HND_W-1:0] left_handle,
   input  wire logic [SKL_KEY_W-1:0] right_key,
   input  wire logic [SKL_HND_W-1:0] right_handle,
   output logic                      le,
   output logic                      eq,
   output logic [SKL_KEY_W-1:0]      key,
   output logic [SKL_HND_W-1:0]      handle
);

   logic [SKL_KEY_W-1:0] key_ff, key_in;
   logic [SKL_HND_W-1:0] handle_ff, handle_in;

   assign le = occupied && (key_ff <= cmd.key);
   assign eq = occupied && (key_ff == cmd.key);

   always_comb begin
      key_in    = key_ff;
      handle_in = handle_ff;
      if (cmd.insert_en && !le) begin
         // first slot past the boundary takes the new entry, the rest shift up
         if (prev_le) begin
            key_in    = cmd.key;
            handle_in = cmd.handle;
         end else begin
            key_in    = left_key;
            handle_in = left_handle;
         end
      end else if (cmd.remove_en && from_index) begin
         key_in    = right_key;
         handle_in = right_handle;
      end
   end

   always_ff @(posedge clock) begin
      key_ff    <= key_in;
      handle_ff <= handle_in;
   end

   assign key    = key_ff;
   assign handle = handle_ff;

endmodule
`default_nettype wire

/* rtl/sorted_key_list_table.sv */
`default_nettype none
// Latency: a command taken at one edge has its result on the rsp_ ports,
//   marked by rsp_strobe, during the very next cycle.
// Throughput: one command per cycle while busy is low; every slot cell compares
//   and shifts in parallel.
// Reset: synchronous, active high; clears the entry count and the strobe.
//   busy is high only while reset is asserted. Results cannot be stalled.
// ----------------------------------------------------------------------------
// sorted_key_list_table: fixed-capacity table sorted by unsigned key
// A chain of slot cells keeps entries in ascending key order. Supports
// stable insert, lookup of first match, read at index and remove at index.
// ----------------------------------------------------------------------------
module sorted_key_list_table
   import skl_pkg::*;
#(
   parameter int CAPACITY = SKL_CAPACITY
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic [SKL_CMD_W-1:0]     req_command,
   input  wire logic [SKL_KEY_W-1:0]     req_key,
   input  wire logic [SKL_HND_W-1:0]     req_record_handle,
   input  wire logic [SKL_SLOT_W-1:0]    req_slot_index,
   output logic                          rsp_strobe,
   output logic [SKL_STAT_W-1:0]         rsp_status,
   output logic [SKL_OUT_IDX_W-1:0]      rsp_found_index,
   output logic [SKL_KEY_W-1:0]          rsp_found_key,
   output logic [SKL_HND_W-1:0]          rsp_found_handle,
   output logic [SKL_OUT_CNT_W-1:0]      rsp_entry_count,
   output logic                          rsp_is_empty
);

   localparam int IW   = $clog2(CAPACITY);        // slot index width
   localparam int CW   = $clog2(CAPACITY + 1);    // count width
   localparam int CMPW = (CW > SKL_SLOT_W) ? CW : SKL_SLOT_W;
   localparam int SLOT_REACH = 2 ** SKL_SLOT_W;   // slots reachable by req_slot_index

   logic accept;
   assign busy   = reset;
   assign accept = start && !busy;

   // ---------------------------------------------------------------------
   // entry count
   // ---------------------------------------------------------------------
   logic [CW-1:0] count_ff, count_in;
   logic          full;
   logic          idx_valid;

   assign full      = (count_ff == CW'(CAPACITY));
   assign idx_valid = CMPW'(req_slot_index) < CMPW'(count_ff);

   // ---------------------------------------------------------------------
   // slot cell chain
   // ---------------------------------------------------------------------
   skl_cell_cmd_type              cell_cmd;
   logic [CAPACITY-1:0]           occupied, prev_le, from_index, le, eq;
   logic [CAPACITY-1:0]           ins_oh, hit_oh, rd_oh;
   logic [SKL_KEY_W-1:0]          cell_key    [CAPACITY];
   logic [SKL_HND_W-1:0]          cell_handle [CAPACITY];

   assign cell_cmd.insert_en = accept && (req_command == CMD_INSERT) && !full;
   assign cell_cmd.remove_en = accept && (req_command == CMD_REMOVE) && idx_valid;
   assign cell_cmd.key       = req_key;
   assign cell_cmd.handle    = req_record_handle;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam int LEFT  = (i == 0) ? 0 : i - 1;
      localparam int RIGHT = (i == CAPACITY - 1) ? i : i + 1;

      assign occupied[i] = count_ff > CW'(i);

      if (i == 0) begin : g_head
         assign prev_le[i] = 1'b1;
         assign hit_oh[i]  = eq[i];
      end else begin : g_body
         assign prev_le[i] = le[LEFT];
         // equal keys sit together, so the first match has no match on its left
         assign hit_oh[i]  = eq[i] && !eq[LEFT];
      end

      // boundary between entries that stay and entries that move up
      assign ins_oh[i] = prev_le[i] && !le[i];

      if (i < SLOT_REACH) begin : g_reach
         assign from_index[i] = req_slot_index <= SKL_SLOT_W'(i);
         assign rd_oh[i]      = req_slot_index == SKL_SLOT_W'(i);
      end else begin : g_far
         assign from_index[i] = 1'b1;
         assign rd_oh[i]      = 1'b0;
      end

      skl_cell u_cell (
         .clock        (clock),
         .cmd          (cell_cmd),
         .occupied     (occupied[i]),
         .prev_le      (prev_le[i]),
         .from_index   (from_index[i]),
         .left_key     (cell_key[LEFT]),
         .left_handle  (cell_handle[LEFT]),
         .right_key    (cell_key[RIGHT]),
         .right_handle (cell_handle[RIGHT]),
         .le           (le[i]),
         .eq           (eq[i]),
         .key          (cell_key[i]),
         .handle       (cell_handle[i])
      );
   end

   // ---------------------------------------------------------------------
   // one-hot selects folded down to index and entry
   // ---------------------------------------------------------------------
   logic [IW-1:0]        ins_pos, hit_pos;
   logic                 hit_any;
   logic [SKL_KEY_W-1:0] hit_key, rd_key;
   logic [SKL_HND_W-1:0] hit_hnd, rd_hnd;

   always_comb begin
      ins_pos = '0;
      hit_pos = '0;
      hit_key = '0;
      hit_hnd = '0;
      rd_key  = '0;
      rd_hnd  = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (ins_oh[i]) ins_pos = ins_pos | IW'(i);
         if (hit_oh[i]) begin
            hit_pos = hit_pos | IW'(i);
            hit_key = hit_key | cell_key[i];
            hit_hnd = hit_hnd | cell_handle[i];
         end
         if (rd_oh[i]) begin
            rd_key = rd_key | cell_key[i];
            rd_hnd = rd_hnd | cell_handle[i];
         end
      end
   end

   assign hit_any = |hit_oh;

   // ---------------------------------------------------------------------
   // result beat
   // ---------------------------------------------------------------------
   logic [SKL_STAT_W-1:0]    status_in;
   logic [SKL_OUT_IDX_W-1:0] index_in;
   logic [SKL_KEY_W-1:0]     rkey_in;
   logic [SKL_HND_W-1:0]     rhnd_in;

   always_comb begin
      status_in = ST_OK;
      index_in  = '0;
      rkey_in   = '0;
      rhnd_in   = '0;
      count_in  = count_ff;
      unique case (req_command)
         CMD_INSERT: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               index_in = SKL_OUT_IDX_W'(ins_pos);
               count_in = count_ff + CW'(1);
            end
         end
         CMD_LOOKUP: begin
            if (hit_any) begin
               index_in = SKL_OUT_IDX_W'(hit_pos);
               rkey_in  = hit_key;
               rhnd_in  = hit_hnd;
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         CMD_READ, CMD_REMOVE: begin
            if (!idx_valid) begin
               status_in = ST_RANGE;
            end else begin
               index_in = req_slot_index;
               rkey_in  = rd_key;
               rhnd_in  = rd_hnd;
               if (req_command == CMD_REMOVE) count_in = count_ff - CW'(1);
            end
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   logic                     strobe_ff;
   logic [SKL_STAT_W-1:0]    status_ff;
   logic [SKL_OUT_IDX_W-1:0] index_ff;
   logic [SKL_KEY_W-1:0]     rkey_ff;
   logic [SKL_HND_W-1:0]     rhnd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         strobe_ff <= accept;
         if (accept) count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         index_ff  <= index_in;
         rkey_ff   <= rkey_in;
         rhnd_ff   <= rhnd_in;
      end
   end

   // count only moves on an accepted command, so it is the post-command count
   assign rsp_strobe       = strobe_ff;
   assign rsp_status       = status_ff;
   assign rsp_found_index  = index_ff;
   assign rsp_found_key    = rkey_ff;
   assign rsp_found_handle = rhnd_ff;
   assign rsp_entry_count  = SKL_OUT_CNT_W'(count_ff);
   assign rsp_is_empty     = (count_ff == '0);

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count past capacity");

   a_one_beat_per_cmd: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("command without result beat");

   a_no_spurious_beat: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_strobe)
      else $error("result beat without command");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && req_command == CMD_INSERT && !full) |=>
         (count_ff == $past(count_ff) + CW'(1)))
      else $error("insert did not grow the table");

   a_hit_key_match: assert property (@(posedge clock) disable iff (reset)
      (accept && req_command == CMD_LOOKUP) |=>
         (rsp_status != ST_OK || rsp_found_key == $past(req_key)))
      else $error("lookup hit returned a different key");

endmodule
`default_nettype wire
